// ===== design/sapm_pkg.sv =====
// sapm_pkg: shared constants and types for the SYN / ARP-reply packet monitor.
// No dependencies; used by sapm_srcmem, sapm_search and syn_arp_packet_monitor.

package sapm_pkg;

  // Source table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int FLAGS_W = 8;
  localparam int IP_W    = 32;
  localparam int ETYPE_W = 16;
  localparam int OPC_W   = 16;
  localparam int TOT_W   = 32;
  localparam int DIST_W  = 9;

  // Header codes
  localparam logic [FLAGS_W-1:0] FLAGS_SYN_ONLY = 8'h02;
  localparam logic [ETYPE_W-1:0] ETYPE_ARP      = 16'h0806;
  localparam logic [OPC_W-1:0]   ARP_OP_REPLY   = 16'd2;

  // Search request from the top level to the scan sequencer
  typedef struct packed {
    logic             start;
    logic [IP_W-1:0]  key;
    logic [CNT_W-1:0] count;
  } srch_req_t;

  // Search response, done pulses for one cycle
  typedef struct packed {
    logic done;
    logic found;
  } srch_rsp_t;

endpackage

// ===== design/sapm_srcmem.sv =====
// sapm_srcmem: source address table, one write port and one registered read port.
// Depends on sapm_pkg for depth and widths.

module sapm_srcmem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [sapm_pkg::IDX_W-1:0] wr_addr,
  input  logic [sapm_pkg::IP_W-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [sapm_pkg::IDX_W-1:0] rd_addr,
  output logic [sapm_pkg::IP_W-1:0]  rd_data
);

  logic [sapm_pkg::IP_W-1:0] mem [sapm_pkg::TABLE_DEPTH];
  logic [sapm_pkg::IP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sapm_search.sv =====
// sapm_search: scan sequencer with one shared 32-bit comparator.
// Walks the stored entries one per cycle. Depends on sapm_pkg.

module sapm_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sapm_pkg::srch_req_t        req,
  output sapm_pkg::srch_rsp_t        rsp,
  output logic                       rd_en,
  output logic [sapm_pkg::IDX_W-1:0] rd_addr,
  input  logic [sapm_pkg::IP_W-1:0]  rd_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                 st_r, st_nxt;
  logic [sapm_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [sapm_pkg::CNT_W-1:0] last_r, last_nxt;
  logic [sapm_pkg::IP_W-1:0]  key_r, key_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic                       found_r, found_nxt;
  logic                       hit;
  logic [sapm_pkg::CNT_W-1:0] idx_inc;

  // the shared compare unit: read data arrives in the cycle after its address
  assign hit     = cmp_vld_r && (rd_data == key_r);
  assign idx_inc = idx_r + sapm_pkg::CNT_W'(1);
  assign rd_en   = (st_r == S_SCAN);
  assign rd_addr = idx_r[sapm_pkg::IDX_W-1:0];

  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    key_nxt     = key_r;
    found_nxt   = found_r;
    cmp_vld_nxt = 1'b0;
    rsp.done    = 1'b0;
    rsp.found   = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (req.start) begin
          key_nxt   = req.key;
          last_nxt  = req.count;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          st_nxt    = (req.count == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_vld_nxt = 1'b1;
        idx_nxt     = idx_inc;
        found_nxt   = found_r | hit;
        if (idx_inc == last_r) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        rsp.done  = 1'b1;
        rsp.found = found_r | hit;
        st_nxt    = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
  end

endmodule

// ===== design/syn_arp_packet_monitor.sv =====
// syn_arp_packet_monitor: top level of the SYN / ARP-reply packet monitor.
// Depends on sapm_pkg, sapm_srcmem and sapm_search.
//
// Usage notes
//   Input channel (in_*): parsed header fields of one packet per transfer,
//   valid/stall handshake. in_stall is low only while the block is idle.
//   Result channel (out_*): one result per packet with both counters, the
//   distinct-source count and the new/full flags, held in an output register.
//   Throughput is one packet at a time. A pure SYN packet scans the source
//   table one entry per cycle through a single compare unit, over the N
//   stored sources (up to 256); after the search drains, the result is
//   loaded into the output register and then the next packet is taken.
//   Any other packet goes straight from idle to the final load, with no search.
//   A waiting result does not block the next packet from being taken; only
//   the final load into the output register waits for the receiver.
//   If out_stall is held, the result stays put and the next packet is parked
//   once its work is finished.
//   Reset (rst_n low, synchronous) clears counters, the source count and the
//   handshake state. The table itself is not cleared: only entries below the
//   source count are ever read, so no clearing pass is needed.
//   Counters saturate at all ones; once the table is full, new sources are
//   dropped and reported through out_table_full.

module syn_arp_packet_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sapm_pkg::FLAGS_W-1:0]  in_tcp_flags,
  input  logic [sapm_pkg::IP_W-1:0]     in_src_ip,
  input  logic [sapm_pkg::ETYPE_W-1:0]  in_ether_type,
  input  logic [sapm_pkg::OPC_W-1:0]    in_arp_opcode,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sapm_pkg::TOT_W-1:0]    out_syn_total,
  output logic [sapm_pkg::DIST_W-1:0]   out_distinct_sources,
  output logic [sapm_pkg::TOT_W-1:0]    out_arp_reply_total,
  output logic                          out_source_was_new,
  output logic                          out_table_full
);

  // packet flow: idle -> (search) -> finish/load result
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_FIN  = 2'd2;

  logic [1:0] st_r, st_nxt;

  // running state
  logic [sapm_pkg::TOT_W-1:0] syn_cnt_r, syn_cnt_nxt;
  logic [sapm_pkg::TOT_W-1:0] arp_cnt_r, arp_cnt_nxt;
  logic [sapm_pkg::CNT_W-1:0] count_r, count_nxt;

  // per-packet context
  logic                      is_syn_r, is_syn_nxt;
  logic                      is_arp_r, is_arp_nxt;
  logic [sapm_pkg::IP_W-1:0] key_r, key_nxt;
  logic                      found_r, found_nxt;

  // output register
  logic                        out_vld_r, out_vld_nxt;
  logic [sapm_pkg::TOT_W-1:0]  out_syn_r, out_arp_r;
  logic [sapm_pkg::DIST_W-1:0] out_dist_r;
  logic                        out_new_r, out_full_r;

  logic                        in_xfer, out_xfer, load;
  logic                        new_src, room;
  logic [31:0]                 cnt_ext;

  sapm_pkg::srch_req_t         srch_req;
  sapm_pkg::srch_rsp_t         srch_rsp;

  logic                        rd_en, wr_en;
  logic [sapm_pkg::IDX_W-1:0]  rd_addr;
  logic [sapm_pkg::IP_W-1:0]   rd_data;

  assign in_stall = (st_r != T_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_vld_r && !out_stall;

  // result goes out once the output register is free or being emptied
  assign load    = (st_r == T_FIN) && (!out_vld_r || !out_stall);
  assign new_src = is_syn_r && !found_r;
  assign room    = (count_r < sapm_pkg::CNT_W'(sapm_pkg::TABLE_DEPTH));
  assign wr_en   = load && new_src && room;

  // search kicks off in the cycle of the transfer, key straight from the port
  assign srch_req.start = in_xfer && (in_tcp_flags == sapm_pkg::FLAGS_SYN_ONLY);
  assign srch_req.key   = in_src_ip;
  assign srch_req.count = count_r;

  sapm_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (srch_req),
    .rsp     (srch_rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sapm_srcmem u_srcmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[sapm_pkg::IDX_W-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    st_nxt      = st_r;
    is_syn_nxt  = is_syn_r;
    is_arp_nxt  = is_arp_r;
    key_nxt     = key_r;
    found_nxt   = found_r;
    syn_cnt_nxt = syn_cnt_r;
    arp_cnt_nxt = arp_cnt_r;
    count_nxt   = count_r;
    out_vld_nxt = out_vld_r && !out_xfer;
    case (st_r)
      T_IDLE: begin
        if (in_xfer) begin
          is_syn_nxt = (in_tcp_flags == sapm_pkg::FLAGS_SYN_ONLY);
          is_arp_nxt = (in_ether_type == sapm_pkg::ETYPE_ARP) &&
                       (in_arp_opcode == sapm_pkg::ARP_OP_REPLY);
          key_nxt    = in_src_ip;
          found_nxt  = 1'b0;
          st_nxt     = srch_req.start ? T_BUSY : T_FIN;
        end
      end
      T_BUSY: begin
        if (srch_rsp.done) begin
          found_nxt = srch_rsp.found;
          st_nxt    = T_FIN;
        end
      end
      T_FIN: begin
        if (load) begin
          // counters hold at all ones
          if (is_syn_r && (syn_cnt_r != '1)) begin
            syn_cnt_nxt = syn_cnt_r + sapm_pkg::TOT_W'(1);
          end
          if (is_arp_r && (arp_cnt_r != '1)) begin
            arp_cnt_nxt = arp_cnt_r + sapm_pkg::TOT_W'(1);
          end
          if (wr_en) begin
            count_nxt = count_r + sapm_pkg::CNT_W'(1);
          end
          out_vld_nxt = 1'b1;
          st_nxt      = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  // distinct count goes to the port in full, as updated by this load
  assign cnt_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_IDLE;
      syn_cnt_r <= '0;
      arp_cnt_r <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      syn_cnt_r <= syn_cnt_nxt;
      arp_cnt_r <= arp_cnt_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_syn_r <= is_syn_nxt;
    is_arp_r <= is_arp_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    if (load) begin
      out_syn_r  <= syn_cnt_nxt;
      out_arp_r  <= arp_cnt_nxt;
      out_dist_r <= cnt_ext[sapm_pkg::DIST_W-1:0];
      out_new_r  <= new_src;
      out_full_r <= new_src && !room;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_syn_total        = out_syn_r;
  assign out_arp_reply_total  = out_arp_r;
  assign out_distinct_sources = out_dist_r;
  assign out_source_was_new   = out_new_r;
  assign out_table_full       = out_full_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------

  // stored source count never runs past the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sapm_pkg::CNT_W'(sapm_pkg::TABLE_DEPTH))
    else $error("source count beyond table depth");

  // a dropped source is always a new one
  a_full_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_source_was_new)
    else $error("table_full without source_was_new");

  // search completion only while a SYN packet is waiting on it
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (st_r == T_BUSY))
    else $error("search done outside busy state");

  // table only grows at a result load, by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      $past(load) && (count_r == $past(count_r) + sapm_pkg::CNT_W'(1)))
    else $error("source count moved outside a result load");

endmodule

// ===== verif/tb_syn_arp_packet_monitor.sv =====
// tb_syn_arp_packet_monitor: self-checking bench for the SYN / ARP-reply packet monitor.
// Drives directed then random packet headers, predicts every result and checks it.
// Depends on sapm_pkg and syn_arp_packet_monitor only.

module tb_syn_arp_packet_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PACKETS = 1280;
  // Covers a SYN scan over a full table plus both sides' longest waits, many
  // times over.
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 300;

  // Codes that are not in the package, used for near misses
  localparam logic [sapm_pkg::ETYPE_W-1:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [sapm_pkg::OPC_W-1:0]   ARP_OP_REQUEST = 16'd1;

  typedef struct packed {
    logic [sapm_pkg::FLAGS_W-1:0] tcp_flags;
    logic [sapm_pkg::IP_W-1:0]    src_ip;
    logic [sapm_pkg::ETYPE_W-1:0] eth_type;
    logic [sapm_pkg::OPC_W-1:0]   arp_opcode;
  } packet_t;

  typedef struct packed {
    logic [sapm_pkg::TOT_W-1:0]  syn_total;
    logic [sapm_pkg::DIST_W-1:0] distinct_sources;
    logic [sapm_pkg::TOT_W-1:0]  arp_reply_total;
    logic                        source_was_new;
    logic                        table_full;
  } tally_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_stall;
  logic [sapm_pkg::FLAGS_W-1:0] in_tcp_flags  = '0;
  logic [sapm_pkg::IP_W-1:0]    in_src_ip     = '0;
  logic [sapm_pkg::ETYPE_W-1:0] in_ether_type = '0;
  logic [sapm_pkg::OPC_W-1:0]   in_arp_opcode = '0;
  logic                         out_valid;
  logic                         out_stall     = 1'b0;
  logic [sapm_pkg::TOT_W-1:0]   out_syn_total;
  logic [sapm_pkg::DIST_W-1:0]  out_distinct_sources;
  logic [sapm_pkg::TOT_W-1:0]   out_arp_reply_total;
  logic                         out_source_was_new;
  logic                         out_table_full;

  syn_arp_packet_monitor DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_tcp_flags         (in_tcp_flags),
    .in_src_ip            (in_src_ip),
    .in_ether_type        (in_ether_type),
    .in_arp_opcode        (in_arp_opcode),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_syn_total        (out_syn_total),
    .out_distinct_sources (out_distinct_sources),
    .out_arp_reply_total  (out_arp_reply_total),
    .out_source_was_new   (out_source_was_new),
    .out_table_full       (out_table_full)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the bench's own copy of the source table and counters.
  // Only entries below stored_sources are ever looked at.
  // ---------------------------------------------------------------------------
  logic [sapm_pkg::IP_W-1:0]  source_list [sapm_pkg::TABLE_DEPTH];
  int unsigned                stored_sources = 0;
  logic [sapm_pkg::TOT_W-1:0] syn_seen       = '0;
  logic [sapm_pkg::TOT_W-1:0] arp_seen       = '0;

  packet_t pending_packets [$];   // built up front, consumed by the driver
  tally_t  awaited_tallies [$];   // predicted results, oldest first
  logic [sapm_pkg::IP_W-1:0] syn_sources [$]; // SYN sources issued so far, for repeats

  int errors      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_new       = 0;
  int n_repeat    = 0;
  int n_dropped   = 0;
  int n_arp_reply = 0;

  // Applies one packet to the predicted state and returns the result it causes.
  function automatic tally_t tally_packet(packet_t p);
    tally_t t;
    bit     hit = 1'b0;
    t = '0;
    if (p.tcp_flags == sapm_pkg::FLAGS_SYN_ONLY) begin
      // counter holds at all ones; the search still happens
      if (syn_seen != '1) syn_seen++;
      for (int unsigned i = 0; i < stored_sources; i++) begin
        if (source_list[sapm_pkg::IDX_W'(i)] == p.src_ip) hit = 1'b1;
      end
      if (hit) begin
        n_repeat++;
      end else begin
        t.source_was_new = 1'b1;
        if (stored_sources < sapm_pkg::TABLE_DEPTH) begin
          source_list[sapm_pkg::IDX_W'(stored_sources)] = p.src_ip;
          stored_sources++;
          n_new++;
        end else begin
          // no room: dropped and flagged, count stays at depth
          t.table_full = 1'b1;
          n_dropped++;
        end
      end
    end
    // the ARP test is independent of the SYN test
    if (p.eth_type == sapm_pkg::ETYPE_ARP && p.arp_opcode == sapm_pkg::ARP_OP_REPLY) begin
      if (arp_seen != '1) arp_seen++;
      n_arp_reply++;
    end
    t.syn_total        = syn_seen;
    t.distinct_sources = sapm_pkg::DIST_W'(stored_sources);
    t.arp_reply_total  = arp_seen;
    return t;
  endfunction

  // Random wait before the next transfer, with the odd run of zeros.
  function automatic int draw_wait(inout int calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic void compare_field(string name, logic [sapm_pkg::TOT_W-1:0] want,
                                        logic [sapm_pkg::TOT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic packet_t make_packet(logic [sapm_pkg::FLAGS_W-1:0] flags,
                                          logic [sapm_pkg::IP_W-1:0]    src,
                                          logic [sapm_pkg::ETYPE_W-1:0] etype,
                                          logic [sapm_pkg::OPC_W-1:0]   op);
    packet_t p;
    p.tcp_flags  = flags;
    p.src_ip     = src;
    p.eth_type   = etype;
    p.arp_opcode = op;
    return p;
  endfunction

  task automatic present_head();
    {in_tcp_flags, in_src_ip, in_ether_type, in_arp_opcode} <= pending_packets[0];
    in_valid <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the pending queue, holds it while stalled and
  // predicts its result at the edge where the transfer happens.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int in_calm  = 0;

  always @(posedge clk) begin : packet_driver
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      awaited_tallies.push_back(tally_packet(pending_packets.pop_front()));
      n_sent++;
      gap = draw_wait(in_calm);
      if (gap == 0 && pending_packets.size() != 0) begin
        present_head();
      end else begin
        in_valid <= 1'b0;
        gap_left = gap;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (pending_packets.size() != 0) begin
        present_head();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction, then
  // stalls the result channel for a random number of cycles.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int out_calm   = 0;

  always @(posedge clk) begin : result_monitor
    tally_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (awaited_tallies.size() == 0) begin
        $error("result transfer with no packet outstanding");
        errors++;
      end else begin
        want = awaited_tallies.pop_front();
        compare_field("syn_total", want.syn_total, out_syn_total);
        compare_field("distinct_sources", sapm_pkg::TOT_W'(want.distinct_sources),
                      sapm_pkg::TOT_W'(out_distinct_sources));
        compare_field("arp_reply_total", want.arp_reply_total, out_arp_reply_total);
        compare_field("source_was_new", sapm_pkg::TOT_W'(want.source_was_new),
                      sapm_pkg::TOT_W'(out_source_was_new));
        compare_field("table_full", sapm_pkg::TOT_W'(want.table_full),
                      sapm_pkg::TOT_W'(out_table_full));
        n_checked++;
      end
      stall_left = draw_wait(out_calm);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    packet_t p;
    int      pick;

    // Directed: field extremes, both tests alone and together, near misses
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, 16'h0000, 16'h0000));
    pending_packets.push_back(make_packet(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'h0000_0000,
                                          16'h0000, 16'h0000));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'hFFFF_FFFF,
                                          16'hFFFF, 16'hFFFF));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'h0000_0000,
                                          ETYPE_IPV4, 16'h0000));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'hFFFF_FFFF,
                                          ETYPE_IPV4, 16'h0000));
    // SYN plus another flag, or all flags but SYN, is not a pure SYN
    pending_packets.push_back(make_packet(8'h03, 32'h0A00_0001, ETYPE_IPV4, 16'h0000));
    pending_packets.push_back(make_packet(8'h12, 32'h0A00_0002, ETYPE_IPV4, 16'h0000));
    pending_packets.push_back(make_packet(8'hFD, 32'h0A00_0003, ETYPE_IPV4, 16'h0000));
    // ARP reply, request and odd opcodes, then a reply opcode on a wrong ether type
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, sapm_pkg::ETYPE_ARP,
                                          sapm_pkg::ARP_OP_REPLY));
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, sapm_pkg::ETYPE_ARP,
                                          ARP_OP_REQUEST));
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, sapm_pkg::ETYPE_ARP,
                                          16'hFFFF));
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, sapm_pkg::ETYPE_ARP,
                                          16'h0200));
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, 16'h0608,
                                          sapm_pkg::ARP_OP_REPLY));
    pending_packets.push_back(make_packet(8'h00, 32'h0000_0000, ETYPE_IPV4,
                                          sapm_pkg::ARP_OP_REPLY));
    // both a pure SYN and an ARP reply, sent twice: both counters move; then a lone pure SYN
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'h8000_0001,
                                          sapm_pkg::ETYPE_ARP, sapm_pkg::ARP_OP_REPLY));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'h8000_0001,
                                          sapm_pkg::ETYPE_ARP, sapm_pkg::ARP_OP_REPLY));
    pending_packets.push_back(make_packet(sapm_pkg::FLAGS_SYN_ONLY, 32'h7FFF_FFFE,
                                          16'h0000, 16'h0000));

    // Random: mostly pure SYNs (new or repeated sources) and ARP replies, so the
    // table fills and later sources get dropped; the rest is near misses and noise.
    for (int n = 0; n < RANDOM_PACKETS; n++) begin
      pick         = $urandom_range(0, 99);
      p.tcp_flags  = sapm_pkg::FLAGS_W'($urandom_range(0, 255));
      p.src_ip     = $urandom();
      p.eth_type   = sapm_pkg::ETYPE_W'($urandom_range(0, 65535));
      p.arp_opcode = sapm_pkg::OPC_W'($urandom_range(0, 65535));
      if (pick < 45) begin
        p.tcp_flags = sapm_pkg::FLAGS_SYN_ONLY;
        if (syn_sources.size() != 0 && $urandom_range(0, 2) == 0)
          p.src_ip = syn_sources[$urandom_range(0, syn_sources.size() - 1)];
        else
          syn_sources.push_back(p.src_ip);
        if ($urandom_range(0, 9) == 0) begin
          p.eth_type   = sapm_pkg::ETYPE_ARP;
          p.arp_opcode = sapm_pkg::ARP_OP_REPLY;
        end
      end else if (pick < 65) begin
        p.eth_type   = sapm_pkg::ETYPE_ARP;
        p.arp_opcode = sapm_pkg::ARP_OP_REPLY;
      end else if (pick < 75) begin
        // one bit away from a match on each test
        p.tcp_flags  = sapm_pkg::FLAGS_SYN_ONLY ^ (8'h01 << $urandom_range(0, 7));
        p.eth_type   = sapm_pkg::ETYPE_ARP;
        p.arp_opcode = sapm_pkg::ARP_OP_REPLY ^ (16'h0001 << $urandom_range(0, 15));
      end else if (pick < 80) begin
        p.eth_type   = sapm_pkg::ETYPE_ARP ^ (16'h0001 << $urandom_range(0, 15));
        p.arp_opcode = sapm_pkg::ARP_OP_REPLY;
      end
      pending_packets.push_back(p);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_packets.size() != 0 || awaited_tallies.size() != 0) @(posedge clk);
    // let any stray result show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets and checked %0d results; %0d were ARP replies.",
             n_sent, n_checked, n_arp_reply);
    $display("SYN sources: %0d stored, %0d seen again, %0d dropped on a full table.",
             n_new, n_repeat, n_dropped);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sapm_pkg.sv
design/sapm_srcmem.sv
design/sapm_search.sv
design/syn_arp_packet_monitor.sv
verif/tb_syn_arp_packet_monitor.sv
